### sv/spor_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the sphere pair overlap resolver.
// No dependencies; used by every spor_* module and the top level.
package spor_pkg;

   localparam int CoordWidth = 32;
   localparam int MagWidth = 31;
   localparam int DiamWidth = 31;
   localparam int SqWidth = 2 * MagWidth;
   localparam int D2Width = 64;
   localparam int QuotWidth = 32;
   localparam int FracBits = 16;
   localparam logic [DiamWidth-1:0] DiamReset = DiamWidth'(64'd1 << FracBits);

   localparam int SqrtIters = 32;
   localparam int SqrtStepsPerStage = 2;
   localparam int SqrtStages = SqrtIters / SqrtStepsPerStage;
   localparam int DivIters = QuotWidth;
   localparam int DivStepsPerStage = 2;
   localparam int DivStages = DivIters / DivStepsPerStage;

   localparam logic CsrDiamIdx = 1'b0;

   typedef logic [CoordWidth-1:0] coord_type;
   typedef coord_type [2:0] vec_type;
   typedef logic [MagWidth-1:0] mag_type;

   typedef struct packed {
      vec_type              a;
      vec_type              b;
      logic [2:0]           neg;
      mag_type [2:0]        mag;
      logic                 hit;
   } ctx_type;

endpackage

### sv/spor_front.sv
`timescale 1ns / 1ps
// Front stages: difference vector, per-axis squares, squared length and contact test.
// Depends on spor_pkg.
module spor_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   ce,
   input  logic                                   in_valid,
   input  spor_pkg::vec_type                      in_a,
   input  spor_pkg::vec_type                      in_b,
   input  logic [spor_pkg::DiamWidth-1:0]         diameter,
   output logic                                   out_valid,
   output spor_pkg::ctx_type                      out_ctx,
   output logic [spor_pkg::D2Width-1:0]           out_d2
);

   logic v1_ff, v2_ff, v3_ff;
   spor_pkg::ctx_type ctx1_ff, ctx2_ff, ctx3_ff, ctx1_in, ctx3_in;
   logic near1_ff, near2_ff, near1_in;
   logic [spor_pkg::SqWidth-1:0] sq_ff [3];
   logic [spor_pkg::SqWidth-1:0] dsq_ff;
   logic [spor_pkg::D2Width-1:0] d2_ff, d2_in;

   always_comb begin
      logic signed [spor_pkg::CoordWidth:0] diff;
      logic [spor_pkg::CoordWidth:0] absval;
      ctx1_in = '0;
      ctx1_in.a = in_a;
      ctx1_in.b = in_b;
      near1_in = 1'b1;
      for (int k = 0; k < 3; k++) begin
         diff = $signed({in_a[k][spor_pkg::CoordWidth-1], in_a[k]})
              - $signed({in_b[k][spor_pkg::CoordWidth-1], in_b[k]});
         absval = diff[spor_pkg::CoordWidth] ? -diff : diff;
         ctx1_in.neg[k] = diff[spor_pkg::CoordWidth];
         ctx1_in.mag[k] = absval[spor_pkg::MagWidth-1:0];
         if (absval[spor_pkg::CoordWidth:spor_pkg::MagWidth] != '0) near1_in = 1'b0;
      end
   end

   always_comb begin
      d2_in = spor_pkg::D2Width'(sq_ff[0]) + spor_pkg::D2Width'(sq_ff[1])
            + spor_pkg::D2Width'(sq_ff[2]);
      ctx3_in = ctx2_ff;
      ctx3_in.hit = near2_ff && (d2_in != '0) && (d2_in < spor_pkg::D2Width'(dsq_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (ce) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         ctx1_ff <= ctx1_in;
         near1_ff <= near1_in;
         ctx2_ff <= ctx1_ff;
         near2_ff <= near1_ff;
         for (int k = 0; k < 3; k++) sq_ff[k] <= ctx1_ff.mag[k] * ctx1_ff.mag[k];
         dsq_ff <= diameter * diameter;
         ctx3_ff <= ctx3_in;
         d2_ff <= d2_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_ctx = ctx3_ff;
   assign out_d2 = d2_ff;

endmodule

### sv/spor_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, a fixed number of bit-pair steps per stage.
// Depends on spor_pkg.
module spor_sqrt (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   ce,
   input  logic                                   in_valid,
   input  spor_pkg::ctx_type                      in_ctx,
   input  logic [spor_pkg::D2Width-1:0]           in_d2,
   output logic                                   out_valid,
   output spor_pkg::ctx_type                      out_ctx,
   output spor_pkg::mag_type                      out_root
);

   localparam int S = spor_pkg::SqrtStages;
   localparam int W = spor_pkg::D2Width;

   logic [W-1:0] n_w [S+1];
   logic [W-1:0] r_w [S+1];
   logic v_w [S+1];
   spor_pkg::ctx_type ctx_w [S+1];

   assign n_w[0] = in_d2;
   assign r_w[0] = '0;
   assign v_w[0] = in_valid;
   assign ctx_w[0] = in_ctx;

   for (genvar s = 0; s < S; s++) begin : g_stage
      logic [W-1:0] n_ff, r_ff, n_in, r_in;
      logic v_ff;
      spor_pkg::ctx_type ctx_ff;

      always_comb begin
         logic [W-1:0] bitv;
         logic [W-1:0] trial;
         n_in = n_w[s];
         r_in = r_w[s];
         for (int t = 0; t < spor_pkg::SqrtStepsPerStage; t++) begin
            bitv = W'(1) << (W - 2 - 2 * (s * spor_pkg::SqrtStepsPerStage + t));
            trial = r_in + bitv;
            if (n_in >= trial) begin
               n_in = n_in - trial;
               r_in = (r_in >> 1) + bitv;
            end else begin
               r_in = r_in >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (ce) begin
            v_ff <= v_w[s];
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            n_ff <= n_in;
            r_ff <= r_in;
            ctx_ff <= ctx_w[s];
         end
      end

      assign n_w[s+1] = n_ff;
      assign r_w[s+1] = r_ff;
      assign v_w[s+1] = v_ff;
      assign ctx_w[s+1] = ctx_ff;
   end

   assign out_valid = v_w[S];
   assign out_ctx = ctx_w[S];
   assign out_root = r_w[S][spor_pkg::MagWidth-1:0];

endmodule

### sv/spor_div.sv
`timescale 1ns / 1ps
// Push magnitudes: gap times axis magnitude, then a pipelined rounded divide by twice the distance.
// Depends on spor_pkg.
module spor_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   ce,
   input  logic                                   in_valid,
   input  spor_pkg::ctx_type                      in_ctx,
   input  spor_pkg::mag_type                      in_root,
   input  logic [spor_pkg::DiamWidth-1:0]         diameter,
   output logic                                   out_valid,
   output spor_pkg::ctx_type                      out_ctx,
   output logic [2:0][spor_pkg::QuotWidth-1:0]    out_quot
);

   localparam int S = spor_pkg::DivStages;
   localparam int QW = spor_pkg::QuotWidth;
   localparam int NW = spor_pkg::SqWidth + 1;

   logic m1_v_ff, m2_v_ff, m3_v_ff;
   spor_pkg::ctx_type m1_ctx_ff, m2_ctx_ff, m3_ctx_ff;
   spor_pkg::mag_type m1_gap_ff, m1_root_ff, m2_root_ff;
   logic [QW-1:0] m1_dv_ff, m2_dv_ff, m3_dv_ff;
   logic [spor_pkg::SqWidth-1:0] m2_prod_ff [3];
   logic [2:0][QW-1:0] m3_rem_ff, m3_lo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         m3_v_ff <= 1'b0;
      end else if (ce) begin
         m1_v_ff <= in_valid;
         m2_v_ff <= m1_v_ff;
         m3_v_ff <= m2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic [NW-1:0] num;
      if (ce) begin
         m1_ctx_ff <= in_ctx;
         m1_gap_ff <= diameter - in_root;
         m1_root_ff <= in_root;
         m1_dv_ff <= {in_root, 1'b0};
         m2_ctx_ff <= m1_ctx_ff;
         m2_root_ff <= m1_root_ff;
         m2_dv_ff <= m1_dv_ff;
         for (int k = 0; k < 3; k++) m2_prod_ff[k] <= m1_ctx_ff.mag[k] * m1_gap_ff;
         m3_ctx_ff <= m2_ctx_ff;
         m3_dv_ff <= m2_dv_ff;
         for (int k = 0; k < 3; k++) begin
            num = NW'(m2_prod_ff[k]) + NW'(m2_root_ff);
            m3_rem_ff[k] <= QW'(num[NW-1:QW]);
            m3_lo_ff[k] <= num[QW-1:0];
         end
      end
   end

   logic [2:0][QW-1:0] rem_w [S+1];
   logic [2:0][QW-1:0] lo_w [S+1];
   logic [QW-1:0] dv_w [S+1];
   logic v_w [S+1];
   spor_pkg::ctx_type ctx_w [S+1];

   assign rem_w[0] = m3_rem_ff;
   assign lo_w[0] = m3_lo_ff;
   assign dv_w[0] = m3_dv_ff;
   assign v_w[0] = m3_v_ff;
   assign ctx_w[0] = m3_ctx_ff;

   for (genvar s = 0; s < S; s++) begin : g_stage
      logic [2:0][QW-1:0] rem_ff, lo_ff, rem_in, lo_in;
      logic [QW-1:0] dv_ff;
      logic v_ff;
      spor_pkg::ctx_type ctx_ff;

      always_comb begin
         logic [QW:0] t;
         rem_in = rem_w[s];
         lo_in = lo_w[s];
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < spor_pkg::DivStepsPerStage; j++) begin
               t = {rem_in[k], lo_in[k][QW-1]};
               if (t >= {1'b0, dv_w[s]}) begin
                  rem_in[k] = QW'(t - {1'b0, dv_w[s]});
                  lo_in[k] = {lo_in[k][QW-2:0], 1'b1};
               end else begin
                  rem_in[k] = t[QW-1:0];
                  lo_in[k] = {lo_in[k][QW-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (ce) begin
            v_ff <= v_w[s];
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            rem_ff <= rem_in;
            lo_ff <= lo_in;
            dv_ff <= dv_w[s];
            ctx_ff <= ctx_w[s];
         end
      end

      assign rem_w[s+1] = rem_ff;
      assign lo_w[s+1] = lo_ff;
      assign dv_w[s+1] = dv_ff;
      assign v_w[s+1] = v_ff;
      assign ctx_w[s+1] = ctx_ff;
   end

   assign out_valid = v_w[S];
   assign out_ctx = ctx_w[S];
   assign out_quot = lo_w[S];

endmodule

### sv/spor_back.sv
`timescale 1ns / 1ps
// Output stage: signed push, apply to both centres, saturate, hold the result item.
// Depends on spor_pkg.
module spor_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   ce,
   input  logic                                   in_valid,
   input  spor_pkg::ctx_type                      in_ctx,
   input  logic [2:0][spor_pkg::QuotWidth-1:0]    in_quot,
   output logic                                   out_valid,
   output spor_pkg::vec_type                      out_a,
   output spor_pkg::vec_type                      out_b,
   output logic                                   out_hit
);

   localparam int CW = spor_pkg::CoordWidth;
   localparam int SW = CW + 2;

   function automatic spor_pkg::coord_type sat(input logic [SW-1:0] v);
      if (v[SW-1:CW-1] == '0 || v[SW-1:CW-1] == '1) begin
         sat = v[CW-1:0];
      end else begin
         sat = v[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
   endfunction

   logic v_ff, hit_ff;
   spor_pkg::vec_type a_ff, b_ff, a_in, b_in;

   always_comb begin
      logic [SW-1:0] dx, ea, eb;
      for (int k = 0; k < 3; k++) begin
         dx = SW'(in_quot[k]);
         if (in_ctx.neg[k]) dx = -dx;
         if (!in_ctx.hit) dx = '0;
         ea = {{2{in_ctx.a[k][CW-1]}}, in_ctx.a[k]};
         eb = {{2{in_ctx.b[k][CW-1]}}, in_ctx.b[k]};
         a_in[k] = sat(ea + dx);
         b_in[k] = sat(eb - dx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (ce) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         a_ff <= a_in;
         b_ff <= b_in;
         hit_ff <= in_ctx.hit;
      end
   end

   assign out_valid = v_ff;
   assign out_a = a_ff;
   assign out_b = b_ff;
   assign out_hit = hit_ff;

endmodule

### sv/sphere_pair_overlap_resolver_unit.sv
`timescale 1ns / 1ps
// Top level of the sphere pair overlap resolver: register port, stall control, pipeline.
// Depends on spor_pkg, spor_front, spor_sqrt, spor_div, spor_back.
//
//   channel | ports      | contents
//   --------+------------+-------------------------------------------------
//   req     | req_t*     | pair of sphere centres, one item per pair
//   rsp     | rsp_t*     | corrected centres, overlap flag in tuser
//   csr     | csr_p*     | sphere_diameter at byte address 0
//
// One item per cycle unless stalled; stages: 3 front, 16 sqrt, 19 divide, 1 output.
// Reset clears the stage valid bits and sets the diameter to 1.0.
// The whole pipeline advances together; while a result waits unread every stage holds,
// and req_tready falls only then.
module sphere_pair_overlap_resolver_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z
   input  logic [191:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // new_first_x, new_first_y, new_first_z, new_second_x, new_second_y, new_second_z
   output logic [191:0]  rsp_tdata,
   // overlapped
   output logic          rsp_tuser,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   logic [spor_pkg::DiamWidth-1:0] diameter_ff;
   logic ce;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == spor_pkg::CsrDiamIdx) ? {1'b0, diameter_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         diameter_ff <= spor_pkg::DiamReset;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == spor_pkg::CsrDiamIdx) begin
         diameter_ff <= csr_pwdata[spor_pkg::DiamWidth-1:0];
      end
   end

   assign ce = !rsp_tvalid || rsp_tready;
   assign req_tready = ce;

   spor_pkg::vec_type in_a, in_b, out_a, out_b;
   assign in_a = req_tdata[95:0];
   assign in_b = req_tdata[191:96];

   logic f_valid, s_valid, d_valid;
   spor_pkg::ctx_type f_ctx, s_ctx, d_ctx;
   logic [spor_pkg::D2Width-1:0] f_d2;
   spor_pkg::mag_type s_root;
   logic [2:0][spor_pkg::QuotWidth-1:0] d_quot;

   spor_front u_front (
      .clock, .reset, .ce,
      .in_valid(req_tvalid && req_tready), .in_a, .in_b, .diameter(diameter_ff),
      .out_valid(f_valid), .out_ctx(f_ctx), .out_d2(f_d2)
   );

   spor_sqrt u_sqrt (
      .clock, .reset, .ce,
      .in_valid(f_valid), .in_ctx(f_ctx), .in_d2(f_d2),
      .out_valid(s_valid), .out_ctx(s_ctx), .out_root(s_root)
   );

   spor_div u_div (
      .clock, .reset, .ce,
      .in_valid(s_valid), .in_ctx(s_ctx), .in_root(s_root), .diameter(diameter_ff),
      .out_valid(d_valid), .out_ctx(d_ctx), .out_quot(d_quot)
   );

   spor_back u_back (
      .clock, .reset, .ce,
      .in_valid(d_valid), .in_ctx(d_ctx), .in_quot(d_quot),
      .out_valid(rsp_tvalid), .out_a, .out_b, .out_hit(rsp_tuser)
   );

   assign rsp_tdata = {out_b, out_a};

endmodule
